/* src/conv2d_u8_reflect101_top_macros.svh */
// assertion macros for the 2-d convolution block checker
`ifndef CONV2D_U8_REFLECT101_TOP_MACROS_SVH
`define CONV2D_U8_REFLECT101_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define C2R_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2r check failed");

// next-cycle implication, sampled on clk, off during rst
`define C2R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("c2r check failed");

`endif

/* src/c2r_pkg.sv */
// shared types and constants of the 2-d convolution block
package c2r_pkg;

  // command codes
  localparam logic [1:0] CMD_COEF  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // register indexes
  localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ANCHOR_COL    = 3'd2;
  localparam logic [2:0] REG_ANCHOR_ROW    = 3'd3;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;
  localparam logic [2:0] REG_OFFSET_VALUE  = 3'd6;

  localparam int CMD_W   = 2;
  localparam int CIDX_W  = 5;
  localparam int COEF_W  = 16;
  localparam int POS_W   = 6;
  localparam int PIX_W   = 8;
  localparam int OUT_W   = 32;
  localparam int REGI_W  = 3;
  localparam int KSZ_W   = 3;
  localparam int ANC_W   = 4;
  localparam int FSZ_W   = 7;
  localparam int PROD_W  = COEF_W + PIX_W;
  localparam int SUM_W   = OUT_W + 2;
  localparam int CRD_W   = 10;

  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctl_t;

  typedef struct packed {
    logic [KSZ_W-1:0]        kernel_width;
    logic [KSZ_W-1:0]        kernel_height;
    logic signed [ANC_W-1:0] anchor_col;
    logic signed [ANC_W-1:0] anchor_row;
    logic [FSZ_W-1:0]        frame_width;
    logic [FSZ_W-1:0]        frame_height;
  } geom_cfg_t;

endpackage

/* src/c2r_ifs.sv */
// handshake channel interfaces: command input, result output, register writes
interface c2r_req_if;
  import c2r_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [CIDX_W-1:0] coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [PIX_W-1:0]  pixel_value;
  modport source (output valid, cmd, coef_index, coef_value, pos_x, pos_y, pixel_value,
                  input ready);
  modport sink (input valid, cmd, coef_index, coef_value, pos_x, pos_y, pixel_value,
                output ready);
endinterface

interface c2r_rsp_if;
  import c2r_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered_value;
  modport source (output valid, filtered_value, input ready);
  modport sink (input valid, filtered_value, output ready);
endinterface

interface c2r_cfg_if;
  import c2r_pkg::*;
  logic              valid;
  logic              ready;
  logic [REGI_W-1:0] index;
  logic [OUT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/conv2d_u8_reflect101_top.sv */
// top level of the 2-d convolution block with reflect-101 border
//
// req carries one command per beat: a coefficient write, a pixel write or a
// query at (pos_x, pos_y). a beat is taken when req.valid and req.ready are high.
// writes do not drop req.ready; it stays high after them.
// a query drops req.ready; the tap sequencer issues kernel_width*kernel_height
// taps, one per cycle, through the registered frame and coefficient reads and a
// single shared multiplier and accumulator. when the result is loaded into the
// output register, rsp.valid rises and req.ready comes back in the same cycle;
// a stalled rsp can delay that load. so a new query is taken only after the
// previous one has loaded its result.
// cfg writes are always taken (cfg.ready is tied high); write them while idle.
// reset clears control state and the coefficient valid bits, so every
// coefficient reads zero; frame pixels are undefined until written and have no
// clearing pass.
// if rsp stalls, the result holds in the output register and writes are still
// accepted; a further query finishes its taps but waits to deliver until the
// output register frees.
module conv2d_u8_reflect101_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_KERNEL = 5
) (
  input logic       clk,
  input logic       rst,
  c2r_req_if.sink   req,
  c2r_rsp_if.source rsp,
  c2r_cfg_if.sink   cfg
);
  import c2r_pkg::*;

  localparam int CIW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;

  // configuration registers
  logic [KSZ_W-1:0]        kernel_width, kernel_height;
  logic signed [ANC_W-1:0] anchor_col, anchor_row;
  logic [FSZ_W-1:0]        frame_width, frame_height;
  logic signed [OUT_W-1:0] offset_value;
  geom_cfg_t               geom;

  logic accept, start, coef_we, pix_we;

  tap_ctl_t                 tap, rd;
  logic [FSZ_W-1:0]         tap_sx, tap_sy;
  logic [CIW-1:0]           tap_cidx;
  logic signed [COEF_W-1:0] rd_coef;
  logic [PIX_W-1:0]         rd_pix;
  logic signed [OUT_W-1:0]  res;
  logic                     done;

  // output register
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_data;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.cmd == CMD_QUERY);
  assign coef_we   = accept && (req.cmd == CMD_COEF);
  assign pix_we    = accept && (req.cmd == CMD_PIXEL);

  assign cfg.ready = 1'b1;

  assign rsp.valid          = out_valid;
  assign rsp.filtered_value = out_data;

  assign geom = '{kernel_width: kernel_width, kernel_height: kernel_height,
                  anchor_col: anchor_col, anchor_row: anchor_row,
                  frame_width: frame_width, frame_height: frame_height};

  // register writes, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_width  <= KSZ_W'(3);
      kernel_height <= KSZ_W'(3);
      anchor_col    <= -ANC_W'(1);
      anchor_row    <= -ANC_W'(1);
      frame_width   <= FSZ_W'(64);
      frame_height  <= FSZ_W'(64);
      offset_value  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KERNEL_WIDTH:  kernel_width  <= cfg.data[KSZ_W-1:0];
        REG_KERNEL_HEIGHT: kernel_height <= cfg.data[KSZ_W-1:0];
        REG_ANCHOR_COL:    anchor_col    <= $signed(cfg.data[ANC_W-1:0]);
        REG_ANCHOR_ROW:    anchor_row    <= $signed(cfg.data[ANC_W-1:0]);
        REG_FRAME_WIDTH:   frame_width   <= cfg.data[FSZ_W-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg.data[FSZ_W-1:0];
        REG_OFFSET_VALUE:  offset_value  <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // query control and result delivery
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && rsp.ready) out_valid <= 1'b0;
          if (start) state <= ST_BUSY;
        end
        ST_BUSY: begin
          // deliver once the output register is free or being emptied
          if (done && (!out_valid || rsp.ready)) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end else if (out_valid && rsp.ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  c2r_tapgen #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_tapgen (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cfg     (geom),
    .pos_x   (req.pos_x),
    .pos_y   (req.pos_y),
    .tap     (tap),
    .tap_sx  (tap_sx),
    .tap_sy  (tap_sy),
    .tap_cidx(tap_cidx)
  );

  c2r_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_KERNEL(MAX_KERNEL)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .coef_we    (coef_we),
    .coef_index (req.coef_index),
    .coef_value (req.coef_value),
    .pix_we     (pix_we),
    .pos_x      (req.pos_x),
    .pos_y      (req.pos_y),
    .pixel_value(req.pixel_value),
    .tap        (tap),
    .tap_sx     (tap_sx),
    .tap_sy     (tap_sy),
    .tap_cidx   (tap_cidx),
    .rd         (rd),
    .rd_coef    (rd_coef),
    .rd_pix     (rd_pix)
  );

  c2r_mac #(
    .MAX_KERNEL(MAX_KERNEL)
  ) u_mac (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .rd          (rd),
    .rd_coef     (rd_coef),
    .rd_pix      (rd_pix),
    .offset_value(offset_value),
    .res         (res),
    .done        (done)
  );

endmodule

/* src/c2r_tapgen.sv */
// tap sequencer: walks the kernel rows then columns and issues reflected coordinates
module c2r_tapgen #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_KERNEL = 5,
  localparam int CIW = $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  c2r_pkg::geom_cfg_t       cfg,
  input  logic [c2r_pkg::POS_W-1:0] pos_x,
  input  logic [c2r_pkg::POS_W-1:0] pos_y,
  output c2r_pkg::tap_ctl_t        tap,
  output logic [c2r_pkg::FSZ_W-1:0] tap_sx,
  output logic [c2r_pkg::FSZ_W-1:0] tap_sy,
  output logic [CIW-1:0]           tap_cidx
);
  import c2r_pkg::*;

  localparam logic signed [CRD_W-1:0] CRD_ONE = CRD_W'(1);
  localparam logic signed [CRD_W-1:0] CRD_TWO = CRD_W'(2);

  logic             running;
  logic [KSZ_W-1:0] kx, ky, kw, kh, ax, ay;
  logic [FSZ_W-1:0] fw, fh;
  logic [POS_W-1:0] px, py;
  logic             last_tap;
  logic signed [CRD_W-1:0] cx, cy;
  logic [FSZ_W-1:0] sx, sy;
  logic [CIW-1:0]   cidx;

  function automatic logic [KSZ_W-1:0] sat_kernel(input logic [KSZ_W-1:0] k);
    if (k == '0) return KSZ_W'(1);
    else if (int'(k) > MAX_KERNEL) return KSZ_W'(MAX_KERNEL);
    else return k;
  endfunction

  function automatic logic [KSZ_W-1:0] pick_anchor(input logic signed [ANC_W-1:0] a,
                                                   input logic [KSZ_W-1:0] k);
    if (a < 0 || a >= $signed({1'b0, k})) return k >> 1;
    else return KSZ_W'(a);
  endfunction

  function automatic logic [FSZ_W-1:0] sat_frame(input logic [FSZ_W-1:0] f, input int maxv);
    if (f == '0) return FSZ_W'(1);
    else if (int'(f) > maxv) return FSZ_W'(maxv);
    else return f;
  endfunction

  // reflect-101 once, then clamp into the frame
  function automatic logic [FSZ_W-1:0] reflect_once(input logic signed [CRD_W-1:0] c,
                                                    input logic [FSZ_W-1:0] n);
    logic signed [CRD_W-1:0] r;
    logic signed [CRD_W-1:0] nn;
    nn = $signed(CRD_W'(n));
    if (c < 0) r = -c;
    else if (c >= nn) r = nn + nn - CRD_TWO - c;
    else r = c;
    if (r < 0) r = '0;
    else if (r > nn - CRD_ONE) r = nn - CRD_ONE;
    return FSZ_W'(r);
  endfunction

  assign last_tap = (kx == kw - KSZ_W'(1)) && (ky == kh - KSZ_W'(1));
  assign cx = $signed(CRD_W'(px)) + $signed(CRD_W'(kx)) - $signed(CRD_W'(ax));
  assign cy = $signed(CRD_W'(py)) + $signed(CRD_W'(ky)) - $signed(CRD_W'(ay));
  assign sx = reflect_once(cx, fw);
  assign sy = reflect_once(cy, fh);
  assign cidx = CIW'(int'(ky) * MAX_KERNEL + int'(kx));

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      tap     <= '0;
    end else begin
      if (start) begin
        kw      <= sat_kernel(cfg.kernel_width);
        kh      <= sat_kernel(cfg.kernel_height);
        ax      <= pick_anchor(cfg.anchor_col, sat_kernel(cfg.kernel_width));
        ay      <= pick_anchor(cfg.anchor_row, sat_kernel(cfg.kernel_height));
        fw      <= sat_frame(cfg.frame_width, MAX_WIDTH);
        fh      <= sat_frame(cfg.frame_height, MAX_HEIGHT);
        px      <= pos_x;
        py      <= pos_y;
        kx      <= '0;
        ky      <= '0;
        running <= 1'b1;
        tap     <= '0;
      end else if (running) begin
        tap       <= '{valid: 1'b1, last: last_tap};
        tap_sx    <= sx;
        tap_sy    <= sy;
        tap_cidx  <= cidx;
        if (last_tap) begin
          running <= 1'b0;
        end else if (kx == kw - KSZ_W'(1)) begin
          kx <= '0;
          ky <= ky + KSZ_W'(1);
        end else begin
          kx <= kx + KSZ_W'(1);
        end
      end else begin
        tap <= '0;
      end
    end
  end

endmodule

/* src/c2r_store.sv */
// frame and coefficient memories with registered tap reads
module c2r_store #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_KERNEL = 5,
  localparam int CIW = $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              coef_we,
  input  logic [c2r_pkg::CIDX_W-1:0]        coef_index,
  input  logic signed [c2r_pkg::COEF_W-1:0] coef_value,
  input  logic                              pix_we,
  input  logic [c2r_pkg::POS_W-1:0]         pos_x,
  input  logic [c2r_pkg::POS_W-1:0]         pos_y,
  input  logic [c2r_pkg::PIX_W-1:0]         pixel_value,
  input  c2r_pkg::tap_ctl_t                 tap,
  input  logic [c2r_pkg::FSZ_W-1:0]         tap_sx,
  input  logic [c2r_pkg::FSZ_W-1:0]         tap_sy,
  input  logic [CIW-1:0]                    tap_cidx,
  output c2r_pkg::tap_ctl_t                 rd,
  output logic signed [c2r_pkg::COEF_W-1:0] rd_coef,
  output logic [c2r_pkg::PIX_W-1:0]         rd_pix
);
  import c2r_pkg::*;

  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(FDEPTH);
  localparam int CDEPTH = MAX_KERNEL * MAX_KERNEL;

  logic [PIX_W-1:0]         frame_mem [FDEPTH];
  logic signed [COEF_W-1:0] coef_mem  [CDEPTH];
  logic [CDEPTH-1:0]        coef_vld;
  logic signed [COEF_W-1:0] coef_q;
  logic                     coef_vld_q;
  logic                     pix_ok, coef_ok;
  logic [AW-1:0]            waddr, raddr;
  logic [CIW-1:0]           cwaddr;

  assign pix_ok  = pix_we && (int'(pos_x) < MAX_WIDTH) && (int'(pos_y) < MAX_HEIGHT);
  assign coef_ok = coef_we && (int'(coef_index) < CDEPTH);
  assign waddr   = AW'(int'(pos_y) * MAX_WIDTH + int'(pos_x));
  assign raddr   = AW'(int'(tap_sy) * MAX_WIDTH + int'(tap_sx));
  assign cwaddr  = CIW'(coef_index);

  always_ff @(posedge clk) begin
    if (pix_ok) frame_mem[waddr] <= pixel_value;
    rd_pix <= frame_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (coef_ok) coef_mem[cwaddr] <= coef_value;
    coef_q     <= coef_mem[tap_cidx];
    coef_vld_q <= coef_vld[tap_cidx];
  end

  // unwritten slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_vld <= '0;
      rd       <= '0;
    end else begin
      if (coef_ok) coef_vld[cwaddr] <= 1'b1;
      rd <= tap;
    end
  end

  assign rd_coef = coef_vld_q ? coef_q : '0;

endmodule

/* src/c2r_mac.sv */
// shared multiply-accumulate with final delta add and 32-bit saturation
module c2r_mac #(
  parameter int MAX_KERNEL = 5,
  localparam int ACC_W = c2r_pkg::PROD_W + $clog2(MAX_KERNEL * MAX_KERNEL + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  c2r_pkg::tap_ctl_t                 rd,
  input  logic signed [c2r_pkg::COEF_W-1:0] rd_coef,
  input  logic [c2r_pkg::PIX_W-1:0]         rd_pix,
  input  logic signed [c2r_pkg::OUT_W-1:0]  offset_value,
  output logic signed [c2r_pkg::OUT_W-1:0]  res,
  output logic                              done
);
  import c2r_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-64'sd2147483648);

  tap_ctl_t                 pv;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     fin;
  logic signed [SUM_W-1:0]  sum;

  assign sum = SUM_W'(acc) + SUM_W'(offset_value);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(rd_coef) * PROD_W'($signed({1'b0, rd_pix}));
    if (start) acc <= '0;
    else if (pv.valid) acc <= acc + ACC_W'(prod);
    if (fin) begin
      if (sum > SAT_HI) res <= OUT_W'(SAT_HI);
      else if (sum < SAT_LO) res <= OUT_W'(SAT_LO);
      else res <= OUT_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv   <= '0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      pv  <= rd;
      fin <= pv.valid && pv.last;
      if (start) done <= 1'b0;
      else if (fin) done <= 1'b1;
    end
  end

endmodule

/* src/c2r_checker.sv */
// port-level checker of the 2-d convolution block and its bind
`include "conv2d_u8_reflect101_top_macros.svh"

module c2r_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic [c2r_pkg::CMD_W-1:0]    req_cmd,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [c2r_pkg::OUT_W-1:0]    rsp_value,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);
  import c2r_pkg::*;

  // a stalled result holds
  `C2R_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value))

  // a query occupies the block, a write does not
  `C2R_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_cmd == CMD_QUERY, !req_ready)
  `C2R_ASSERT_NEXT(a_write_free, req_valid && req_ready && req_cmd != CMD_QUERY, req_ready)

  // a new result only comes out of a running query
  `C2R_ASSERT_SAME(a_rsp_from_query, $rose(rsp_valid), !$past(req_ready))

  // register writes never stall
  `C2R_ASSERT_SAME(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind conv2d_u8_reflect101_top c2r_checker u_c2r_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_cmd  (req.cmd),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_value(rsp.filtered_value),
  .cfg_valid(cfg.valid),
  .cfg_ready(cfg.ready)
);
